### sv/kpi_pkg.sv
// keyframe position interpolator: shared types, widths, codes and helpers
// no dependencies; imported by every other file of the block
package kpi_pkg;

  localparam int TIME_W      = 32;
  localparam int COORD_W     = 32;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int Q_W         = 17;
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = 18;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int RND_W       = ACC_W - 16;
  localparam int MAX_KEYS_DEF = 64;

  localparam logic [Q_W-1:0]   ONE_Q16  = 17'h10000;
  localparam logic [ACC_W-1:0] HALF_Q16 = ACC_W'(32768);

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_QUERY    = 1'b1;
  localparam logic KIND_LINEAR = 1'b0;
  localparam logic KIND_BEZIER = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]             time_v;
    logic                          kind;
    logic [2:0][COORD_W-1:0]       pos;
    logic [2:0][COORD_W-1:0]       ctrl;
  } kpi_key_t;

  typedef struct packed {
    logic mul;
    logic first;
  } kpi_mac_ctl_t;

  function automatic logic [COORD_W-1:0] sat32(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    hi = RND_W'(64'sd2147483647);
    lo = -RND_W'(64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

### sv/kpi_in_if.sv
// input channel of the keyframe interpolator: valid/ready plus payload
// uses kpi_pkg widths
interface kpi_in_if import kpi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [IDX_W-1:0]           key_index;
  logic [TIME_W-1:0]          time_value;
  logic                       motion_kind;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  pos_z;
  logic signed [COORD_W-1:0]  ctrl_x;
  logic signed [COORD_W-1:0]  ctrl_y;
  logic signed [COORD_W-1:0]  ctrl_z;

  modport source (output valid, op, key_index, time_value, motion_kind,
                  pos_x, pos_y, pos_z, ctrl_x, ctrl_y, ctrl_z, input ready);
  modport sink   (input valid, op, key_index, time_value, motion_kind,
                  pos_x, pos_y, pos_z, ctrl_x, ctrl_y, ctrl_z, output ready);
endinterface

### sv/kpi_out_if.sv
// result channel of the keyframe interpolator: valid/ready plus position
// uses kpi_pkg widths
interface kpi_out_if import kpi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  out_x;
  logic signed [COORD_W-1:0]  out_y;
  logic signed [COORD_W-1:0]  out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

### sv/kpi_keymem.sv
// keyframe table: one write port, one registered read port
// uses kpi_pkg key entry type
module kpi_keymem import kpi_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int AW       = $clog2(MAX_KEYS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  kpi_key_t         wdata,
  input  logic [AW-1:0]    raddr,
  output kpi_key_t         rdata
);

  localparam int XW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

  kpi_key_t       mem [MAX_KEYS];
  logic [XW-1:0]  wa_x;
  logic           in_range;

  assign wa_x     = XW'(waddr);
  assign in_range = wa_x < XW'(MAX_KEYS);

  always_ff @(posedge clk) begin
    if (we && in_range) begin
      mem[wa_x[AW-1:0]] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/kpi_div.sv
// restoring divider for the segment fraction: (num << 16) / den, num <= den
// one quotient bit per cycle, 17 quotient bits; uses kpi_pkg widths
module kpi_div import kpi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [Q_W-1:0]    quot
);

  logic [TIME_W:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]  den_r;
  logic [Q_W-1:0]     quot_r;
  logic [4:0]         cnt_r;
  logic               busy_r, done_r;
  logic               ge;
  logic [TIME_W:0]    diff;

  assign ge      = rem_r >= {1'b0, den_r};
  assign diff    = ge ? rem_r - {1'b0, den_r} : rem_r;
  assign rem_nxt = {diff[TIME_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'(Q_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 5'd1;
      busy_r <= cnt_r != 5'd1;
      done_r <= cnt_r == 5'd1;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### sv/kpi_mac.sv
// shared multiply-accumulate unit with q16 rounding on the accumulator
// product registered, then accumulated; uses kpi_pkg widths and control struct
module kpi_mac import kpi_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kpi_mac_ctl_t                ctl,
  input  logic signed [MUL_A_W-1:0]   a,
  input  logic signed [MUL_B_W-1:0]   b,
  output logic signed [RND_W-1:0]     rnd
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  sum;
  logic                     pv_r, first_r;

  assign prod_x = ACC_W'(prod_r);
  assign sum    = acc_r + $signed(HALF_Q16);
  assign rnd    = RND_W'(sum >>> 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      first_r <= 1'b0;
    end else begin
      pv_r    <= ctl.mul;
      first_r <= ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= a * b;
    end
    if (pv_r) begin
      acc_r <= first_r ? prod_x : acc_r + prod_x;
    end
  end

endmodule

### sv/keyframe_position_interpolator_top.sv
// keyframe position interpolator top: sequencer, key search, shared mac and divider
// depends on kpi_pkg, kpi_in_if, kpi_out_if, kpi_keymem, kpi_div, kpi_mac
//
//   channel  | direction | transaction
//   in_if    | sink      | keyframe write (op 0) or position query (op 1)
//   out_if   | source    | one interpolated position per query
//   cfg_     | write     | key_count register
//
// a keyframe write is taken while idle; a query holds off the input (ready low) until
// its result is loaded: read the last key, scan the keys (one key a cycle), run the
// divider, run the shared mac (linear or bezier), then load the output register
// no clearing pass after reset; key_count resets to zero
// the finished result sits in an output register while the next transaction is taken
module keyframe_position_interpolator_top import kpi_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  kpi_in_if.sink           in_if,
  kpi_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRCH  = 3'd1;
  localparam logic [2:0] ST_DIVGO = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_MAC   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
  localparam logic [2:0] ST_LAST  = 3'd6;

  logic [2:0]            state_r;
  logic [CNT_W-1:0]      key_count_r;
  logic [NW-1:0]         n_r, n_nxt;
  logic [TIME_W-1:0]     t_r;
  logic [NW-1:0]         issue_r, chk_idx_r;
  logic                  chk_vld_r, issue_ok;
  logic                  last_lt_r;
  kpi_key_t              wr_key, rd_key, prev_r, cur_r;
  logic                  hit, is_last, is_first;
  logic [TIME_W-1:0]     num_r, den_r;
  logic                  bez_r;
  logic                  div_done;
  logic [Q_W-1:0]        div_q;
  logic [Q_W-1:0]        f_r, g_r;
  logic [Q_W-1:0]        w_r [3];
  logic [2:0]            grp_r, step_r, nterm;
  logic [1:0]            ax;
  kpi_mac_ctl_t          mac_ctl;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [RND_W-1:0]   mac_rnd;
  logic signed [MUL_A_W-1:0] p0, c0, p1;
  logic [2:0][COORD_W-1:0]   res_r;
  logic                  out_vld_r;
  logic [2:0][COORD_W-1:0]   out_r;

  assign n_nxt = (NW'(key_count_r) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count_r);

  assign wr_key.time_v = in_if.time_value;
  assign wr_key.kind   = in_if.motion_kind;
  assign wr_key.pos    = {in_if.pos_z, in_if.pos_y, in_if.pos_x};
  assign wr_key.ctrl   = {in_if.ctrl_z, in_if.ctrl_y, in_if.ctrl_x};

  kpi_keymem #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (in_if.valid && in_if.ready && in_if.op == OP_WRITE),
    .waddr (in_if.key_index),
    .wdata (wr_key),
    .raddr (issue_r[AW-1:0]),
    .rdata (rd_key)
  );

  kpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIVGO),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  kpi_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .rnd   (mac_rnd)
  );

  assign issue_ok = (state_r == ST_SRCH) && (issue_r < n_r);
  assign hit      = rd_key.time_v >= t_r;
  assign is_last  = chk_idx_r == n_r - NW'(1);
  assign is_first = chk_idx_r == '0;

  // mac operand selection
  assign nterm = (grp_r < 3'd3) ? 3'd1 : 3'd3;
  assign ax    = 2'(grp_r - 3'd3);

  always_comb begin
    p0 = '0;
    c0 = '0;
    p1 = '0;
    unique case (ax)
      2'd0: begin
        p0 = MUL_A_W'($signed(prev_r.pos[0]));
        c0 = p0 + MUL_A_W'($signed(prev_r.ctrl[0]));
        p1 = MUL_A_W'($signed(cur_r.pos[0]));
      end
      2'd1: begin
        p0 = MUL_A_W'($signed(prev_r.pos[1]));
        c0 = p0 + MUL_A_W'($signed(prev_r.ctrl[1]));
        p1 = MUL_A_W'($signed(cur_r.pos[1]));
      end
      2'd2: begin
        p0 = MUL_A_W'($signed(prev_r.pos[2]));
        c0 = p0 + MUL_A_W'($signed(prev_r.ctrl[2]));
        p1 = MUL_A_W'($signed(cur_r.pos[2]));
      end
      default: begin
        p0 = '0;
        c0 = '0;
        p1 = '0;
      end
    endcase
  end

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    if (grp_r < 3'd3) begin
      unique case (grp_r)
        3'd0: begin
          mac_a = MUL_A_W'(g_r);
          mac_b = MUL_B_W'(g_r);
        end
        3'd1: begin
          mac_a = MUL_A_W'({g_r, 1'b0});
          mac_b = MUL_B_W'(f_r);
        end
        default: begin
          mac_a = MUL_A_W'(f_r);
          mac_b = MUL_B_W'(f_r);
        end
      endcase
    end else begin
      unique case (step_r)
        3'd0: begin
          mac_a = p0;
          mac_b = MUL_B_W'(w_r[0]);
        end
        3'd1: begin
          mac_a = c0;
          mac_b = MUL_B_W'(w_r[1]);
        end
        default: begin
          mac_a = p1;
          mac_b = MUL_B_W'(w_r[2]);
        end
      endcase
    end
  end

  assign mac_ctl.mul   = (state_r == ST_MAC) && (step_r < nterm);
  assign mac_ctl.first = step_r == 3'd0;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_count_r <= '0;
      chk_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
      issue_r     <= '0;
      grp_r       <= '0;
      step_r      <= '0;
    end else begin
      if (cfg_we) begin
        key_count_r <= cfg_data;
      end
      if (state_r == ST_OUT && (!out_vld_r || out_if.ready)) begin
        out_vld_r <= 1'b1;
      end else if (out_if.valid && out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          chk_vld_r <= 1'b0;
          if (in_if.valid && in_if.op == OP_QUERY) begin
            issue_r <= n_nxt - NW'(1);
            state_r <= (n_nxt == '0) ? ST_OUT : ST_LAST;
          end
        end
        ST_LAST: begin
          chk_vld_r <= 1'b1;
          if (!chk_vld_r) begin
            issue_r <= '0;
          end else begin
            chk_idx_r <= '0;
            issue_r   <= NW'(1);
            state_r   <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (chk_vld_r && (hit || is_last || last_lt_r)) begin
            chk_vld_r <= 1'b0;
            state_r   <= (hit && !is_first) ? ST_DIVGO : ST_OUT;
          end else begin
            chk_vld_r <= issue_ok;
            if (issue_ok) begin
              chk_idx_r <= issue_r;
              issue_r   <= issue_r + NW'(1);
            end
          end
        end
        ST_DIVGO: begin
          chk_vld_r <= 1'b0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          chk_vld_r <= 1'b0;
          if (div_done) begin
            grp_r   <= bez_r ? 3'd0 : 3'd3;
            step_r  <= '0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          chk_vld_r <= 1'b0;
          if (step_r == nterm + 3'd1) begin
            step_r <= '0;
            grp_r  <= grp_r + 3'd1;
            if (grp_r == 3'd5) begin
              state_r <= ST_OUT;
            end
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_OUT: begin
          chk_vld_r <= 1'b0;
          if (!out_vld_r || out_if.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          chk_vld_r <= 1'b0;
          state_r   <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_if.valid) begin
      t_r      <= in_if.time_value;
      n_r      <= n_nxt;
      res_r    <= '0;
    end
    if (state_r == ST_LAST && chk_vld_r) begin
      last_lt_r <= rd_key.time_v < t_r;
      res_r     <= rd_key.pos;
    end
    if (state_r == ST_SRCH && chk_vld_r) begin
      cur_r <= rd_key;
      if (hit || is_last || last_lt_r) begin
        if (!last_lt_r || rd_key.time_v > t_r) begin
          res_r <= rd_key.pos;
        end
        bez_r  <= prev_r.kind == KIND_BEZIER;
        den_r  <= rd_key.time_v - prev_r.time_v;
        num_r  <= (prev_r.kind == KIND_BEZIER) ? t_r - prev_r.time_v
                                                 : rd_key.time_v - t_r;
      end else begin
        prev_r <= rd_key;
      end
    end
    if (state_r == ST_DIV && div_done) begin
      if (bez_r) begin
        f_r <= div_q;
        g_r <= ONE_Q16 - div_q;
      end else begin
        w_r[0] <= div_q;
        w_r[1] <= '0;
        w_r[2] <= ONE_Q16 - div_q;
      end
    end
    if (state_r == ST_MAC && step_r == nterm + 3'd1) begin
      unique case (grp_r)
        3'd0: w_r[0] <= mac_rnd[Q_W-1:0];
        3'd1: w_r[1] <= mac_rnd[Q_W-1:0];
        3'd2: w_r[2] <= mac_rnd[Q_W-1:0];
        3'd3: res_r[0] <= sat32(mac_rnd);
        3'd4: res_r[1] <= sat32(mac_rnd);
        3'd5: res_r[2] <= sat32(mac_rnd);
        default: res_r <= res_r;
      endcase
    end
    if (state_r == ST_OUT && (!out_vld_r || out_if.ready)) begin
      out_r <= res_r;
    end
  end

  assign in_if.ready  = state_r == ST_IDLE;
  assign out_if.valid = out_vld_r;
  assign out_if.out_x = out_r[0];
  assign out_if.out_y = out_r[1];
  assign out_if.out_z = out_r[2];

endmodule
